>>> src/tcpr_pkg.sv
`default_nettype none

package tcpr_pkg;

  // Field widths of the channel words
  localparam int FONT_INDEX_W = 14;
  localparam int FONT_VALUE_W = 8;
  localparam int CELL_COL_W   = 8;
  localparam int CELL_ROW_W   = 7;
  localparam int ENTRY_W      = 16;
  localparam int SUB_COL_W    = 4;
  localparam int SUB_ROW_W    = 5;
  localparam int ADDR_W       = 32;
  localparam int WORD_W       = 32;
  localparam int LANES        = 4;

  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 16;

  // Printable glyph range and the full-intensity level
  localparam logic [7:0] CODE_FIRST     = 8'h21;
  localparam logic [7:0] CODE_LAST      = 8'h7e;
  localparam logic [7:0] FULL_INTENSITY = 8'hff;

  // Input word modes
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_RENDER = 1'b1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LINE_PITCH      = 3'd0,
    REG_BYTES_PER_PIXEL = 3'd1,
    REG_RED_OFFSET      = 3'd2,
    REG_GREEN_OFFSET    = 3'd3,
    REG_BLUE_OFFSET     = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [15:0] line_pitch;
    logic [2:0]  bytes_per_pixel;
    logic [1:0]  red_offset;
    logic [1:0]  green_offset;
    logic [1:0]  blue_offset;
  } cfg_t;

  localparam logic [15:0] LINE_PITCH_RESET      = 16'd4096;
  localparam logic [2:0]  BYTES_PER_PIXEL_RESET = 3'd4;
  localparam logic [1:0]  RED_OFFSET_RESET      = 2'd2;
  localparam logic [1:0]  GREEN_OFFSET_RESET    = 2'd1;
  localparam logic [1:0]  BLUE_OFFSET_RESET     = 2'd0;

  // Sixteen-entry console palette, 0xRRGGBB
  localparam logic [23:0] PALETTE [16] = '{
    24'h000000, 24'h0000a8, 24'h00a800, 24'h00a8a8,
    24'ha80000, 24'ha800a8, 24'ha85700, 24'ha8a8a8,
    24'h333333, 24'h5757ff, 24'h57ff57, 24'h57ffff,
    24'hff5757, 24'hff57ff, 24'hffb10f, 24'hffffff
  };

  // Exact quotient by 255 for x up to 255*255, by the add-and-shift identity.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] sum;
    sum = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return sum[15:8];
  endfunction

endpackage

`default_nettype wire

>>> src/tcpr_if.sv
`default_nettype none

interface tcpr_in_if import tcpr_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    mode;
  logic [FONT_INDEX_W-1:0] font_index;
  logic [FONT_VALUE_W-1:0] font_value;
  logic [CELL_COL_W-1:0]   cell_col;
  logic [CELL_ROW_W-1:0]   cell_row;
  logic [ENTRY_W-1:0]      entry;
  logic [SUB_COL_W-1:0]    sub_col;
  logic [SUB_ROW_W-1:0]    sub_row;

  modport source (
    output valid, mode, font_index, font_value, cell_col, cell_row, entry, sub_col, sub_row,
    input  ready
  );
  modport sink (
    input  valid, mode, font_index, font_value, cell_col, cell_row, entry, sub_col, sub_row,
    output ready
  );
endinterface

interface tcpr_out_if import tcpr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] pixel_address;
  logic [WORD_W-1:0] pixel_word;
  logic [LANES-1:0]  byte_enable;

  modport source (output valid, pixel_address, pixel_word, byte_enable, input ready);
  modport sink (input valid, pixel_address, pixel_word, byte_enable, output ready);
endinterface

interface tcpr_cfg_if import tcpr_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> src/tcpr_cfg_regs.sv
`default_nettype none

module tcpr_cfg_regs import tcpr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  tcpr_cfg_if.sink   cfg,
  output cfg_t       regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.line_pitch      <= LINE_PITCH_RESET;
      regs.bytes_per_pixel <= BYTES_PER_PIXEL_RESET;
      regs.red_offset      <= RED_OFFSET_RESET;
      regs.green_offset    <= GREEN_OFFSET_RESET;
      regs.blue_offset     <= BLUE_OFFSET_RESET;
    end else if (cfg.valid) begin
      unique case (cfg_reg_e'(cfg.index))
        REG_LINE_PITCH:      regs.line_pitch      <= cfg.data;
        REG_BYTES_PER_PIXEL: regs.bytes_per_pixel <= cfg.data[2:0];
        REG_RED_OFFSET:      regs.red_offset      <= cfg.data[1:0];
        REG_GREEN_OFFSET:    regs.green_offset    <= cfg.data[1:0];
        REG_BLUE_OFFSET:     regs.blue_offset     <= cfg.data[1:0];
        default: begin
          // Unmapped indexes are ignored.
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> src/tcpr_glyph_ram.sv
`default_nettype none

module tcpr_glyph_ram #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds between reads, so a stalled reader keeps its byte.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> src/text_cell_pixel_renderer_unit.sv
`default_nettype none

// Text cell pixel renderer. Load words (mode 0) write one glyph intensity byte
// into the on-chip glyph store and produce no result; render words (mode 1)
// produce one framebuffer write per pixel: the byte address of the pixel and a
// 32-bit word with red, green and blue at their configured byte lanes, plus
// byte enables. A render word whose pixel lies outside the cell produces
// nothing. The block takes one word every clock and delivers one result every
// clock while the output is not stalled. Each result passes three registers:
// the registered read of the glyph memory at the accepting edge, the blend
// stage and the output register. The glyph memory has one write port and one
// read port. The glyph store has no reset and no clearing pass: it must be
// loaded before any glyph that is rendered, and glyphs beyond the store render
// as background. Configuration registers may be written only while no render
// is in flight. An output register with a per-stage ready chain lets new words
// enter while a finished result waits to be taken.

module text_cell_pixel_renderer_unit import tcpr_pkg::*; #(
  parameter int GLYPH_WIDTH  = 9,
  parameter int GLYPH_HEIGHT = 18,
  parameter int FONT_DEPTH   = 16384
) (
  input  logic       clk,
  input  logic       rst,
  tcpr_cfg_if.sink   cfg,
  tcpr_in_if.sink    pixel_in,
  tcpr_out_if.source pixel_out
);

  localparam int AW        = $clog2(FONT_DEPTH);
  localparam int CELL_SIZE = GLYPH_WIDTH * GLYPH_HEIGHT;
  // Highest glyph address is one below 94 full cells.
  localparam int GADDR_W   = $clog2(94 * CELL_SIZE);
  localparam int ROW_W     = $clog2((1 << CELL_ROW_W) * GLYPH_HEIGHT);
  localparam int COL_W     = $clog2((1 << CELL_COL_W) * GLYPH_WIDTH);
  localparam logic [5:0] GW_LIMIT = 6'(GLYPH_WIDTH);
  localparam logic [5:0] GH_LIMIT = 6'(GLYPH_HEIGHT);

  // Configuration registers
  cfg_t regs;

  tcpr_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // Input decode. A word is taken whenever the first stage can move on.
  logic                  s1_ready;
  logic                  s2_ready;
  logic                  s3_ready;
  logic                  in_acc;
  logic                  inside_cell;
  logic                  render_take;
  logic [7:0]            code;
  logic                  printable;
  logic [6:0]            code_off;
  logic [GADDR_W-1:0]    glyph_addr;
  logic                  glyph_in_store;
  logic                  load_in_store;
  logic                  mem_we;
  logic                  mem_re;
  logic [7:0]            glyph_rdata;

  assign pixel_in.ready = s1_ready;
  assign in_acc         = pixel_in.valid && s1_ready;

  assign inside_cell = ({2'b00, pixel_in.sub_col} < GW_LIMIT) &&
                       ({1'b0, pixel_in.sub_row} < GH_LIMIT);
  assign render_take = in_acc && (pixel_in.mode == MODE_RENDER) && inside_cell;

  assign code      = pixel_in.entry[7:0];
  assign printable = (code >= CODE_FIRST) && (code <= CODE_LAST);
  assign code_off  = 7'(code - CODE_FIRST);

  // Glyph bytes are stored cell after cell, row-major within a cell.
  assign glyph_addr = GADDR_W'(code_off * CELL_SIZE) +
                      GADDR_W'(pixel_in.sub_row * GLYPH_WIDTH) +
                      GADDR_W'(pixel_in.sub_col);
  assign glyph_in_store = 32'(glyph_addr) < 32'(FONT_DEPTH);
  assign load_in_store  = 32'(pixel_in.font_index) < 32'(FONT_DEPTH);

  assign mem_we = in_acc && (pixel_in.mode == MODE_LOAD) && load_in_store;
  // The memory is read only when a render word enters the first stage, so its
  // output register doubles as that stage's glyph byte while it is stalled.
  assign mem_re = render_take;

  tcpr_glyph_ram #(
    .DEPTH (FONT_DEPTH),
    .AW    (AW)
  ) u_glyph_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (AW'(pixel_in.font_index)),
    .wdata (pixel_in.font_value),
    .re    (mem_re),
    .raddr (AW'(glyph_addr)),
    .rdata (glyph_rdata)
  );

  // Stage 1: glyph byte arrives; palette colours and pixel coordinates held.
  logic             s1_valid;
  logic             s1_use_glyph;
  logic [23:0]      s1_fg;
  logic [23:0]      s1_bg;
  logic [ROW_W-1:0] s1_row;
  logic [COL_W-1:0] s1_col;

  assign s1_ready = !s1_valid || s2_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= render_take;
    end
  end

  always_ff @(posedge clk) begin
    if (render_take) begin
      s1_use_glyph <= printable && glyph_in_store;
      s1_fg        <= PALETTE[pixel_in.entry[11:8]];
      s1_bg        <= PALETTE[pixel_in.entry[15:12]];
      s1_row       <= ROW_W'(pixel_in.cell_row * GLYPH_HEIGHT + pixel_in.sub_row);
      s1_col       <= COL_W'(pixel_in.cell_col * GLYPH_WIDTH + pixel_in.sub_col);
    end
  end

  // Stage 2: blend products and address products. A zero intensity gives the
  // background colour exactly, which covers blank codes and missing glyphs.
  logic [7:0]          t;
  logic [15:0]         blend_sum [3];
  logic                s2_valid;
  logic [15:0]         s2_sum [3];
  logic [ROW_W+15:0]   s2_row_off;
  logic [COL_W+2:0]    s2_col_off;

  assign t = s1_use_glyph ? glyph_rdata : 8'd0;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      blend_sum[c] = 16'(t) * 16'(s1_fg[8*c +: 8]) +
                     16'(FULL_INTENSITY - t) * 16'(s1_bg[8*c +: 8]);
    end
  end

  assign s2_ready = !s2_valid || s3_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s2_ready) begin
      for (int c = 0; c < 3; c++) begin
        s2_sum[c] <= blend_sum[c];
      end
      s2_row_off <= (ROW_W+16)'(s1_row) * (ROW_W+16)'(regs.line_pitch);
      s2_col_off <= (COL_W+3)'(s1_col) * (COL_W+3)'(regs.bytes_per_pixel);
    end
  end

  // Stage 3: divide by 255, final address add and lane placement into the
  // output register. Blue takes precedence over green, green over red.
  logic [7:0]        chan [3];
  logic [WORD_W-1:0] word_next;
  logic [LANES-1:0]  enable_next;
  logic [ADDR_W-1:0] address_next;
  logic              out_valid;
  logic [ADDR_W-1:0] out_address;
  logic [WORD_W-1:0] out_word;
  logic [LANES-1:0]  out_enable;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      chan[c] = div255(s2_sum[c]);
    end
    for (int lane = 0; lane < LANES; lane++) begin
      if (regs.blue_offset == 2'(lane)) begin
        word_next[8*lane +: 8] = chan[0];
        enable_next[lane]      = 1'b1;
      end else if (regs.green_offset == 2'(lane)) begin
        word_next[8*lane +: 8] = chan[1];
        enable_next[lane]      = 1'b1;
      end else if (regs.red_offset == 2'(lane)) begin
        word_next[8*lane +: 8] = chan[2];
        enable_next[lane]      = 1'b1;
      end else begin
        word_next[8*lane +: 8] = 8'd0;
        enable_next[lane]      = 1'b0;
      end
    end
  end

  assign address_next = ADDR_W'(s2_row_off) + ADDR_W'(s2_col_off);

  assign s3_ready = !out_valid || pixel_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s3_ready) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid && s3_ready) begin
      out_address <= address_next;
      out_word    <= word_next;
      out_enable  <= enable_next;
    end
  end

  assign pixel_out.valid         = out_valid;
  assign pixel_out.pixel_address = out_address;
  assign pixel_out.pixel_word    = out_word;
  assign pixel_out.byte_enable   = out_enable;

  // A load word never enters the render pipeline.
  a_load_no_render: assert property (@(posedge clk) disable iff (rst)
    in_acc && (pixel_in.mode == MODE_LOAD) |=> !s1_valid)
    else $error("load word entered the render pipeline");

  // A stalled first stage keeps its glyph byte and coordinates.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s2_ready |=> s1_valid && $stable(glyph_rdata) && $stable(s1_row))
    else $error("stalled first stage lost its contents");

  // The glyph memory never sees a write and a read in the same cycle.
  a_mem_one_port: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re))
    else $error("glyph memory written and read together");

  // A new result only appears when the second stage held one.
  a_out_from_s2: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s2_valid))
    else $error("result appeared without a source");

endmodule

`default_nettype wire
